@@ sv/grid_path_to_motion_actions_defines.svh @@
// Assertion macros for the checker in gpma_checker.sv.
`ifndef GRID_PATH_TO_MOTION_ACTIONS_DEFINES_SVH
`define GRID_PATH_TO_MOTION_ACTIONS_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define GPMA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpma assertion failed");

// Next-cycle implication, masked during reset.
`define GPMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpma assertion failed");

// Next-cycle implication that also holds across reset.
`define GPMA_ASSERT_NEXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gpma assertion failed");

`endif

@@ sv/gpma_pkg.sv @@
`timescale 1ns / 1ps

package gpma_pkg;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_LEFT    = 2'd1,
    ACT_RIGHT   = 2'd2,
    ACT_INVALID = 2'd3
  } action_t;

  // Headings: 0 up, 1 right, 2 down, 3 left.
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // Turn needed, as (target heading - current heading) mod 4.
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_CW    = 2'd1;
  localparam logic [1:0] TURN_BACK  = 2'd2;
  localparam logic [1:0] TURN_CCW   = 2'd3;

  localparam int MAX_BEATS  = 3;
  localparam int QUEUE_SIZE = 4;

  typedef struct packed {
    logic       is_first;
    logic [7:0] col;
    logic [7:0] row;
    logic [1:0] init_heading;
  } in_beat_t;

  typedef struct packed {
    action_t    action;
    logic [1:0] heading_after;
    logic       last;
  } out_beat_t;

  // Results caused by one point, in order from beats[0].
  typedef struct packed {
    logic [1:0]                count;
    out_beat_t [MAX_BEATS-1:0] beats;
  } bundle_t;

endpackage

@@ sv/gpma_step.sv @@
`timescale 1ns / 1ps

module gpma_step
  import gpma_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_beat_t in_data,
  output bundle_t  bundle
);

  localparam int CW = (COORD_BITS < 8) ? COORD_BITS : 8;

  logic [CW-1:0] prev_col;
  logic [CW-1:0] prev_row;
  logic [1:0]    cur_heading;
  logic          path_active;

  logic [CW-1:0] c;
  logic [CW-1:0] r;
  logic [CW:0]   c_x, r_x, pc_x, pr_x;
  logic          go_up, go_right, go_down, go_left, neighbour;
  logic [1:0]    dir;
  logic [1:0]    turn;

  assign c    = in_data.col[CW-1:0];
  assign r    = in_data.row[CW-1:0];
  assign c_x  = {1'b0, c};
  assign r_x  = {1'b0, r};
  assign pc_x = {1'b0, prev_col};
  assign pr_x = {1'b0, prev_row};

  // Widened compares so that coordinates never wrap at the grid edge.
  assign go_up    = (c == prev_col) && (r_x + (CW+1)'(1) == pr_x);
  assign go_down  = (c == prev_col) && (r_x == pr_x + (CW+1)'(1));
  assign go_right = (r == prev_row) && (c_x == pc_x + (CW+1)'(1));
  assign go_left  = (r == prev_row) && (c_x + (CW+1)'(1) == pc_x);
  assign neighbour = go_up || go_down || go_right || go_left;

  always_comb begin
    dir = HEAD_UP;
    if (go_right) dir = HEAD_RIGHT;
    if (go_down)  dir = HEAD_DOWN;
    if (go_left)  dir = HEAD_LEFT;
  end

  assign turn = dir - cur_heading;

  always_comb begin
    bundle = '0;
    if (accept && !in_data.is_first && path_active) begin
      if (!neighbour) begin
        bundle.count    = 2'd1;
        bundle.beats[0] = '{ACT_INVALID, cur_heading, 1'b1};
      end else begin
        case (turn)
          TURN_NONE: begin
            bundle.count    = 2'd1;
            bundle.beats[0] = '{ACT_FORWARD, dir, 1'b1};
          end
          TURN_CW: begin
            bundle.count    = 2'd2;
            bundle.beats[0] = '{ACT_RIGHT, dir, 1'b0};
            bundle.beats[1] = '{ACT_FORWARD, dir, 1'b1};
          end
          TURN_CCW: begin
            bundle.count    = 2'd2;
            bundle.beats[0] = '{ACT_LEFT, dir, 1'b0};
            bundle.beats[1] = '{ACT_FORWARD, dir, 1'b1};
          end
          TURN_BACK: begin
            bundle.count    = 2'd3;
            bundle.beats[0] = '{ACT_RIGHT, cur_heading + 2'd1, 1'b0};
            bundle.beats[1] = '{ACT_RIGHT, dir, 1'b0};
            bundle.beats[2] = '{ACT_FORWARD, dir, 1'b1};
          end
          default: begin
            bundle = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_col    <= '0;
      prev_row    <= '0;
      cur_heading <= HEAD_UP;
      path_active <= 1'b0;
    end else if (accept) begin
      if (in_data.is_first) begin
        prev_col    <= c;
        prev_row    <= r;
        cur_heading <= in_data.init_heading;
        path_active <= 1'b1;
      end else if (path_active) begin
        if (!neighbour) begin
          path_active <= 1'b0;
        end else begin
          prev_col    <= c;
          prev_row    <= r;
          cur_heading <= dir;
        end
      end
    end
  end

endmodule

@@ sv/gpma_queue.sv @@
`timescale 1ns / 1ps

module gpma_queue
  import gpma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bundle_t   bundle,
  input  logic      out_stall,
  output logic      out_valid,
  output out_beat_t out_data,
  output logic      in_stall
);

  logic [2:0]  count;
  logic [2:0]  count_next;
  out_beat_t   slots [QUEUE_SIZE];
  out_beat_t   slots_next [QUEUE_SIZE];
  logic        pop;
  logic [2:0]  cnt_pop;
  logic [2:0]  off;

  assign out_valid = (count != 3'd0);
  assign out_data  = slots[0];
  assign pop       = out_valid && !out_stall;
  assign cnt_pop   = count - {2'b0, pop};
  // Take a point only if its worst case of three beats still fits.
  assign in_stall  = (cnt_pop > 3'd1);

  always_comb begin
    off = '0;
    for (int i = 0; i < QUEUE_SIZE; i++) begin
      if (pop && i < QUEUE_SIZE - 1) begin
        slots_next[i] = slots[i+1];
      end else begin
        slots_next[i] = slots[i];
      end
    end
    // Append the new beats just behind whatever survives the pop.
    for (int i = 0; i < QUEUE_SIZE; i++) begin
      off = 3'(i) - cnt_pop;
      if (push && 3'(i) >= cnt_pop && off < {1'b0, bundle.count}) begin
        slots_next[i] = bundle.beats[off[1:0]];
      end
    end
    count_next = cnt_pop + (push ? {1'b0, bundle.count} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slots <= slots_next;
  end

endmodule

@@ sv/grid_path_to_motion_actions.sv @@
`timescale 1ns / 1ps
// The actions of a point join the action queue when the point is taken, behind any beats
// still waiting. Throughput: one action beat per cycle while out_stall is low; a point causes
//   one action for straight on or an invalid step, two for a quarter turn and three for a
//   reversal. Points that cause no action are taken one per cycle while the queue has room.
// The four-entry action queue sets the rate: a point is taken while at most one beat remains
// after this cycle's pop. Reset: synchronous, active high; clears path state and queue.

module grid_path_to_motion_actions
  import gpma_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // A point beat is taken on valid with no stall.
  logic    accept;
  bundle_t bundle;

  assign accept = in_valid && !in_stall;

  // Judge the step against the held previous point and heading, advance the
  // path state, and hand the zero to three actions of this point along.
  gpma_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .bundle  (bundle)
  );

  // Hold the actions in order and release one beat per cycle while out_stall is low; the head
  // entry is the output register, so a single waiting beat never blocks
  // the input.
  gpma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .bundle    (bundle),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .in_stall  (in_stall)
  );

endmodule

@@ sv/gpma_checker.sv @@
`timescale 1ns / 1ps
`include "grid_path_to_motion_actions_defines.svh"

module gpma_checker
  import gpma_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // Reset leaves an empty queue ready for a point.
  `GPMA_ASSERT_NEXT_ALL(a_reset_empty, clk, rst, !in_stall && !out_valid)

  // Beats of one point follow without a gap.
  `GPMA_ASSERT_NEXT(a_no_gap, clk, rst, out_valid && !out_stall && !out_data.last, out_valid)

  // Forward and invalid close a point; turns never do.
  `GPMA_ASSERT_NOW(a_last_kind, clk, rst, out_valid, out_data.last == (out_data.action == ACT_FORWARD || out_data.action == ACT_INVALID))

  // A stalled beat holds.
  `GPMA_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind grid_path_to_motion_actions gpma_checker u_gpma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/grid_path_to_motion_actions_tb.sv @@
`timescale 1ns / 1ps

module grid_path_to_motion_actions_tb;
  import gpma_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // Points waiting to be offered, and actions the block still owes us.
  in_beat_t  points_to_send[$];
  out_beat_t actions_due[$];

  // Idle odds per side, in percent; set by the sequencer between phases.
  int send_idle_pct = 11;
  int recv_idle_pct = 49;

  int errors = 0;
  int beats_seen = 0;
  int hold_left = 0;
  out_beat_t oldest;

  // Predictor's copy of the path tracker.
  logic [7:0] trk_col = '0;
  logic [7:0] trk_row = '0;
  logic [1:0] trk_heading = HEAD_UP;
  bit         trk_active = 1'b0;

  grid_path_to_motion_actions uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_beat_t motion(action_t act, logic [1:0] hd, logic fin);
    out_beat_t b;
    b.action        = act;
    b.heading_after = hd;
    b.last          = fin;
    return b;
  endfunction

  // Append one owed action at the tail.
  function automatic void owe(input out_beat_t b);
    actions_due = {actions_due, b};
  endfunction

  // Work out the actions one accepted point causes and advance the tracker.
  task automatic plan_actions(input in_beat_t p);
    int         dx;
    int         dy;
    logic [1:0] want;
    logic [1:0] turn;
    bit         neighbour;
    dx = int'(p.col) - int'(trk_col);
    dy = int'(p.row) - int'(trk_row);
    // A first point only seeds the path; it owes nothing.
    if (p.is_first) begin
      trk_col     = p.col;
      trk_row     = p.row;
      trk_heading = p.init_heading;
      trk_active  = 1'b1;
      return;
    end
    // Drop points that arrive with no path open.
    if (!trk_active) return;
    neighbour = 1'b1;
    want      = HEAD_UP;
    if (dx == 0 && dy == -1) want = HEAD_UP;
    else if (dx == 1 && dy == 0) want = HEAD_RIGHT;
    else if (dx == 0 && dy == 1) want = HEAD_DOWN;
    else if (dx == -1 && dy == 0) want = HEAD_LEFT;
    else neighbour = 1'b0;
    // Anything but a four-neighbour step (same cell, diagonal, far jump or a
    // wrap across the grid edge) closes the path with a single invalid beat.
    if (!neighbour) begin
      trk_active = 1'b0;
      owe(motion(ACT_INVALID, trk_heading, 1'b1));
      return;
    end
    turn = want - trk_heading;
    case (turn)
      TURN_CW: begin
        trk_heading = trk_heading + 2'd1;
        owe(motion(ACT_RIGHT, trk_heading, 1'b0));
      end
      TURN_CCW: begin
        trk_heading = trk_heading - 2'd1;
        owe(motion(ACT_LEFT, trk_heading, 1'b0));
      end
      TURN_BACK: begin
        // A reversal is two right turns.
        trk_heading = trk_heading + 2'd1;
        owe(motion(ACT_RIGHT, trk_heading, 1'b0));
        trk_heading = trk_heading + 2'd1;
        owe(motion(ACT_RIGHT, trk_heading, 1'b0));
      end
      default: ;
    endcase
    owe(motion(ACT_FORWARD, trk_heading, 1'b1));
    trk_col = p.col;
    trk_row = p.row;
  endtask

  task automatic add_point(input logic first, input logic [7:0] c, input logic [7:0] r,
                           input logic [1:0] hd);
    in_beat_t p;
    p.is_first     = first;
    p.col          = c;
    p.row          = r;
    p.init_heading = hd;
    points_to_send = {points_to_send, p};
  endtask

  // Queue mostly well-formed paths of random shape, with some noise: stray
  // points outside a path, repeated cells and far jumps.
  task automatic queue_paths(input int count);
    int         added;
    int         len;
    logic [7:0] c;
    logic [7:0] r;
    logic [1:0] d;
    added = 0;
    while (added < count) begin
      if ($urandom_range(9) == 0)
        add_point(1'b0, 8'($urandom), 8'($urandom), 2'($urandom));
      // Start near the grid edges now and then, so walks cross them.
      c = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0) : 8'($urandom);
      r = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0) : 8'($urandom);
      add_point(1'b1, c, r, 2'($urandom));
      len = $urandom_range(11);
      added += 1 + len;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(14) == 0) begin
          if ($urandom_range(1)) begin
            c = 8'($urandom);
            r = 8'($urandom);
          end
        end else begin
          d = 2'($urandom_range(3));
          case (d)
            HEAD_UP:    r = r - 8'd1;
            HEAD_RIGHT: c = c + 8'd1;
            HEAD_DOWN:  r = r + 8'd1;
            default:    c = c - 8'd1;
          endcase
        end
        add_point(1'b0, c, r, 2'($urandom));
      end
    end
  endtask

  // Hold until every point is taken and every owed action has come back.
  task automatic drain();
    while (points_to_send.size() != 0 || in_valid || actions_due.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on each accepted beat, then offer the next point or idle.
  // A stalled beat is held as it is.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) plan_actions(in_data);
      if (!in_valid || !in_stall) begin
        if (points_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= points_to_send[0];
          points_to_send.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted beat against the oldest owed action and
  // drive the receiver's stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (actions_due.size() == 0) begin
          $error("unexpected beat: action %0d heading_after %0d last %0d",
                 out_data.action, out_data.heading_after, out_data.last);
          errors++;
        end else begin
          oldest = actions_due[0];
          actions_due.delete(0);
          if (out_data.action !== oldest.action) begin
            $error("action: expected %0d, got %0d", oldest.action, out_data.action);
            errors++;
          end
          if (out_data.heading_after !== oldest.heading_after) begin
            $error("heading_after: expected %0d, got %0d",
                   oldest.heading_after, out_data.heading_after);
            errors++;
          end
          if (out_data.last !== oldest.last) begin
            $error("last: expected %0d, got %0d", oldest.last, out_data.last);
            errors++;
          end
        end
        // Once, hold off for a long stretch so the action queue fills and the
        // block has to stall its input while points keep coming.
        if (beats_seen == 100) hold_left = 250;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    // Directed: stray point after reset, every turn kind, bad steps, edges.
    add_point(1'b0, 8'd255, 8'd255, HEAD_LEFT);   // no path open: ignored
    add_point(1'b1, 8'd0, 8'd0, HEAD_DOWN);
    add_point(1'b0, 8'd0, 8'd1, 2'd0);            // straight on
    add_point(1'b0, 8'd1, 8'd1, 2'd3);            // quarter turn anticlockwise
    add_point(1'b0, 8'd1, 8'd2, 2'd0);            // quarter turn clockwise
    add_point(1'b0, 8'd1, 8'd1, 2'd0);            // reversal
    add_point(1'b0, 8'd0, 8'd1, 2'd0);            // left from up
    add_point(1'b0, 8'd0, 8'd1, 2'd0);            // same cell: invalid
    add_point(1'b0, 8'd0, 8'd2, 2'd2);            // after invalid: ignored
    add_point(1'b1, 8'd10, 8'd10, HEAD_RIGHT);    // one-point path
    add_point(1'b1, 8'd255, 8'd255, HEAD_LEFT);
    add_point(1'b0, 8'd254, 8'd255, 2'd1);        // forward, heading left
    add_point(1'b0, 8'd255, 8'd255, 2'd1);        // reversal at the far corner
    add_point(1'b0, 8'd0, 8'd255, 2'd1);          // column wrap: invalid
    add_point(1'b1, 8'd0, 8'd0, HEAD_UP);
    add_point(1'b0, 8'd255, 8'd0, 2'd0);          // column wrap downward: invalid
    add_point(1'b1, 8'd0, 8'd0, HEAD_DOWN);
    add_point(1'b0, 8'd0, 8'd255, 2'd0);          // row wrap: invalid
    add_point(1'b1, 8'd128, 8'd127, HEAD_RIGHT);
    add_point(1'b0, 8'd129, 8'd128, 2'd0);        // diagonal: invalid
    add_point(1'b1, 8'd7, 8'd7, HEAD_UP);
    add_point(1'b0, 8'd7, 8'd9, 2'd0);            // two cells away: invalid
    queue_paths(180);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    drain();
    send_idle_pct = 49;
    recv_idle_pct = 11;
    queue_paths(145);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_paths(110);
    drain();
    // Let any stray beat surface before judging.
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("** grid_path_to_motion_actions: PASSED **");
    end else begin
      $display("** grid_path_to_motion_actions: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** grid_path_to_motion_actions: FAILED **");
    $finish;
  end

endmodule
